### rtl/core/tlrp_pkg.sv
`timescale 1ns / 1ps

package tlrp_pkg;

  localparam int unsigned REC_LEN_W = 24;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] RADIX      = 8'd10;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NONDIGIT = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_EARLY    = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           record_type;
    logic [REC_LEN_W-1:0] record_length;
    logic [7:0]           data_byte;
    logic                 record_end;
    logic [1:0]           error;
  } out_item_t;

  typedef struct packed {
    logic     vld;
    in_item_t item;
  } in_stage_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } res_t;

endpackage

### rtl/core/tlrp_ifs.sv
`timescale 1ns / 1ps

interface tlrp_in_if import tlrp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface tlrp_out_if import tlrp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [7:0]           record_type;
  logic [REC_LEN_W-1:0] record_length;
  logic [7:0]           data_byte;
  logic                 record_end;
  logic [1:0]           error;

  modport source (output valid, output kind, output record_type, output record_length,
                  output data_byte, output record_end, output error, input ready);
  modport sink   (input valid, input kind, input record_type, input record_length,
                  input data_byte, input record_end, input error, output ready);
endinterface

### rtl/core/tlrp_in_reg.sv
`timescale 1ns / 1ps

module tlrp_in_reg import tlrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tlrp_in_if.sink    in_if,
  input  logic       adv,
  output in_stage_t  stage
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;
  logic     take;

  assign in_if.ready = !vld_r || adv;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.in_byte      <= in_if.in_byte;
      item_r.end_of_input <= in_if.end_of_input;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

### rtl/core/tlrp_parse.sv
`timescale 1ns / 1ps

module tlrp_parse import tlrp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_stage_t stage,
  input  logic      adv,
  output res_t      res
);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             type_hold_r, type_hold_nxt;
  logic [LENGTH_BITS-1:0] accum_r, accum_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;

  logic                   step;
  logic [7:0]             b;
  logic                   last;
  logic [7:0]             digit;
  logic                   is_digit;
  logic [LENGTH_BITS+3:0] acc_w;
  logic [LENGTH_BITS+3:0] next_len;
  logic                   ovf;
  logic [31:0]            accum_ext;
  logic                   empty;
  logic                   fin;

  assign step      = stage.vld && adv;
  assign b         = stage.item.in_byte;
  assign last      = stage.item.end_of_input;
  assign digit     = b - CHAR_ZERO;
  assign is_digit  = digit < RADIX;
  assign acc_w     = {4'b0000, accum_r};
  assign next_len  = (acc_w << 3) + (acc_w << 1) + {{LENGTH_BITS{1'b0}}, digit[3:0]};
  assign ovf       = |next_len[LENGTH_BITS+3:LENGTH_BITS];
  assign accum_ext = 32'(accum_r);
  assign empty     = (accum_r == '0);
  assign fin       = (left_r <= LENGTH_BITS'(1));

  always_comb begin
    phase_nxt     = phase_r;
    type_hold_nxt = type_hold_r;
    accum_nxt     = accum_r;
    left_nxt      = left_r;

    res.vld                = 1'b0;
    res.item.kind          = KIND_HEADER;
    res.item.record_type   = type_hold_r;
    res.item.record_length = '0;
    res.item.data_byte     = '0;
    res.item.record_end    = 1'b0;
    res.item.error         = ERR_NONE;

    if (step) begin
      case (phase_r)
        PH_TYPE: begin
          type_hold_nxt = b;
          accum_nxt     = '0;
          left_nxt      = '0;
          phase_nxt     = PH_LEN;
        end
        PH_LEN: begin
          if (b == CHAR_COLON) begin
            res.vld                = 1'b1;
            res.item.kind          = KIND_HEADER;
            res.item.record_length = accum_ext[REC_LEN_W-1:0];
            res.item.record_end    = empty;
            res.item.error         = (!empty && last) ? ERR_EARLY : ERR_NONE;
            left_nxt               = accum_r;
            phase_nxt              = empty ? PH_TYPE : PH_DATA;
          end else if (is_digit) begin
            if (ovf) begin
              res.vld        = 1'b1;
              res.item.kind  = KIND_ERROR;
              res.item.error = ERR_OVERFLOW;
              phase_nxt      = PH_SKIP;
            end else begin
              accum_nxt = next_len[LENGTH_BITS-1:0];
            end
          end else begin
            res.vld        = 1'b1;
            res.item.kind  = KIND_ERROR;
            res.item.error = ERR_NONDIGIT;
            phase_nxt      = PH_SKIP;
          end
        end
        PH_DATA: begin
          res.vld                = 1'b1;
          res.item.kind          = KIND_DATA;
          res.item.record_length = accum_ext[REC_LEN_W-1:0];
          res.item.data_byte     = b;
          res.item.record_end    = fin;
          res.item.error         = (!fin && last) ? ERR_EARLY : ERR_NONE;
          if (fin) begin
            left_nxt  = '0;
            phase_nxt = PH_TYPE;
          end else begin
            left_nxt = left_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
          end
        end
        default: begin
        end
      endcase

      if (last) begin
        phase_nxt = PH_TYPE;
        left_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      type_hold_r <= '0;
      accum_r     <= '0;
      left_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      type_hold_r <= type_hold_nxt;
      accum_r     <= accum_nxt;
      left_r      <= left_nxt;
    end
  end

endmodule

### rtl/core/tlrp_out_reg.sv
`timescale 1ns / 1ps

module tlrp_out_reg import tlrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res,
  output logic       adv,
  tlrp_out_if.source out_if
);

  logic      vld_r;
  out_item_t item_r;

  assign adv = !vld_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      item_r <= res.item;
    end
  end

  assign out_if.valid         = vld_r;
  assign out_if.kind          = item_r.kind;
  assign out_if.record_type   = item_r.record_type;
  assign out_if.record_length = item_r.record_length;
  assign out_if.data_byte     = item_r.data_byte;
  assign out_if.record_end    = item_r.record_end;
  assign out_if.error         = item_r.error;

endmodule

### rtl/core/typed_length_prefixed_record_parser_top.sv
`timescale 1ns / 1ps

// Typed length-prefixed record parser: one byte per transaction on in_if, at most one
// result per byte on out_if. A byte passes an input register, the parser state update,
// and a result register. A byte is taken every cycle as long as out_if keeps up; a stalled
// result holds both registers. Each record is a type
// byte, a decimal length of up to LENGTH_BITS bits, a colon and the payload bytes. A bad
// length gives one error result and skips to end_of_input; a string that ends with
// payload still owed is flagged with error 3 and that record should be discarded.

module typed_length_prefixed_record_parser_top import tlrp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  tlrp_in_if.sink    in_if,
  tlrp_out_if.source out_if
);

  in_stage_t stage;
  res_t      res;
  logic      adv;

  tlrp_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .adv   (adv),
    .stage (stage)
  );

  tlrp_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .stage (stage),
    .adv   (adv),
    .res   (res)
  );

  tlrp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .adv    (adv),
    .out_if (out_if)
  );

endmodule

### sim/typed_length_prefixed_record_parser_top_tb.sv
`timescale 1ns / 1ps

module typed_length_prefixed_record_parser_top_tb;
  import tlrp_pkg::*;

  typedef enum logic [1:0] {
    AWAIT_TYPE,
    LENGTH_DIGITS,
    PAYLOAD,
    SKIP_TO_END
  } parse_state_t;

  localparam longint unsigned LEN_MAX = (64'd1 << REC_LEN_W) - 1;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tlrp_in_if  in_if ();
  tlrp_out_if out_if ();

  typed_length_prefixed_record_parser_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // parser shadow state
  parse_state_t         st;
  logic [7:0]           type_hold;
  logic [REC_LEN_W-1:0] len_acc;
  logic [REC_LEN_W-1:0] payload_left;

  out_item_t  pending_results[$];
  logic [7:0] enc_bytes[$];
  int         mismatches   = 0;
  int         bytes_parsed = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         hold_req  = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    out_item_t       r;
    bit              emit;
    logic [7:0]      dig;
    longint unsigned nxt;
    bit              fin;
    r    = '0;
    emit = 1'b0;
    dig  = b - CHAR_ZERO;
    if (st != SKIP_TO_END) bytes_parsed++;
    case (st)
      AWAIT_TYPE: begin
        type_hold    = b;
        len_acc      = '0;
        payload_left = '0;
        st           = LENGTH_DIGITS;
      end
      LENGTH_DIGITS: begin
        if (b == CHAR_COLON) begin
          emit            = 1'b1;
          r.kind          = KIND_HEADER;
          r.record_length = len_acc;
          r.record_end    = (len_acc == 0);
          r.error         = (len_acc != 0 && last) ? ERR_EARLY : ERR_NONE;
          payload_left    = len_acc;
          st              = (len_acc == 0) ? AWAIT_TYPE : PAYLOAD;
        end else if (dig < RADIX) begin
          nxt = longint'(len_acc) * RADIX + dig;
          if (nxt > LEN_MAX) begin
            emit    = 1'b1;
            r.kind  = KIND_ERROR;
            r.error = ERR_OVERFLOW;
            st      = SKIP_TO_END;
          end else begin
            len_acc = nxt[REC_LEN_W-1:0];
          end
        end else begin
          emit    = 1'b1;
          r.kind  = KIND_ERROR;
          r.error = ERR_NONDIGIT;
          st      = SKIP_TO_END;
        end
      end
      PAYLOAD: begin
        fin             = (payload_left <= 1);
        emit            = 1'b1;
        r.kind          = KIND_DATA;
        r.record_length = len_acc;
        r.data_byte     = b;
        r.record_end    = fin;
        r.error         = (!fin && last) ? ERR_EARLY : ERR_NONE;
        payload_left    = fin ? '0 : payload_left - REC_LEN_W'(1);
        if (fin) st = AWAIT_TYPE;
      end
      default: ;
    endcase
    if (last) begin
      st           = AWAIT_TYPE;
      payload_left = '0;
    end
    if (emit) begin
      r.record_type = type_hold;
      pending_results.push_back(r);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.end_of_input <= last;
    do @(posedge clk); while (!in_if.ready);
    parse_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_string();
    for (int i = 0; i < enc_bytes.size(); i++) begin
      send_byte(enc_bytes[i], i == enc_bytes.size() - 1);
    end
    enc_bytes.delete();
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      enc_bytes.push_back(s[i]);
    end
  endfunction

  function automatic void add_header(input longint unsigned len);
    enc_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(7) == 0) push_text("0");
    push_text($sformatf("%0d", len));
    enc_bytes.push_back(CHAR_COLON);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(100, 300);
  endfunction

  function automatic void add_record(input int len);
    add_header(len);
    repeat (len) enc_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    logic [7:0] d;
    do begin
      b = 8'($urandom_range(255));
      d = b - CHAR_ZERO;
    end while (d < RADIX || b == CHAR_COLON);
    return b;
  endfunction

  // receiver: random stalls plus a counted long hold on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_seen + 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic bit field_bad(input string name, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
    if (want_v === got_v) return 1'b0;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
    return 1'b1;
  endfunction

  out_item_t want;
  bit        bad;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d type 0x%0h len %0d",
                 $time, out_if.kind, out_if.record_type, out_if.record_length);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        bad  = 1'b0;
        bad |= field_bad("kind", want.kind, out_if.kind);
        bad |= field_bad("record_type", want.record_type, out_if.record_type);
        bad |= field_bad("record_length", want.record_length, out_if.record_length);
        bad |= field_bad("data_byte", want.data_byte, out_if.data_byte);
        bad |= field_bad("record_end", want.record_end, out_if.record_end);
        bad |= field_bad("error", want.error, out_if.error);
        if (bad) mismatches++;
      end
    end
  end

  task automatic test_extremes();
    enc_bytes.push_back(8'h00);
    push_text("0");
    enc_bytes.push_back(CHAR_COLON);
    enc_bytes.push_back(8'hFF);
    push_text("2");
    enc_bytes.push_back(CHAR_COLON);
    enc_bytes.push_back(8'h00);
    enc_bytes.push_back(8'hFF);
    send_string();
  endtask

  task automatic test_early_end();
    push_text("T");
    send_string();
    push_text("L5");
    send_string();
    push_text("C2");
    enc_bytes.push_back(CHAR_COLON);
    send_string();
    push_text("P2");
    enc_bytes.push_back(CHAR_COLON);
    push_text("a");
    send_string();
  endtask

  task automatic test_bad_length();
    push_text("Nxy");
    send_string();
    push_text("O16777216");
    send_string();
  endtask

  task automatic test_random(input int n_bytes, input int idle_pct, input int stall_pct);
    int start;
    int mode;
    int cut;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    start          = bytes_parsed;
    while (bytes_parsed - start < n_bytes) begin
      mode = $urandom_range(99);
      if (mode < 80) begin
        repeat ($urandom_range(1, 4)) add_record(pick_len());
      end else if (mode < 88) begin
        enc_bytes.push_back(8'($urandom_range(255)));
        if ($urandom_range(1)) push_text($sformatf("%0d", $urandom_range(999)));
        enc_bytes.push_back(non_digit());
        repeat ($urandom_range(3)) enc_bytes.push_back(8'($urandom_range(255)));
      end else if (mode < 94) begin
        enc_bytes.push_back(8'($urandom_range(255)));
        push_text($sformatf("%0d", $urandom_range(32'hFFFF_FFFF, 32'h0100_0000)));
        repeat ($urandom_range(3)) enc_bytes.push_back(8'($urandom_range(255)));
      end else if (mode < 96) begin
        add_header(LEN_MAX - $urandom_range(3));
        repeat ($urandom_range(4)) enc_bytes.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 2)) add_record(pick_len());
        cut = $urandom_range(1, enc_bytes.size());
        while (enc_bytes.size() > cut) void'(enc_bytes.pop_back());
      end
      send_string();
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req++;
    repeat (4) add_record($urandom_range(10, 20));
    send_string();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    st                 = AWAIT_TYPE;
    type_hold          = '0;
    len_acc            = '0;
    payload_left       = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_early_end();
    test_bad_length();
    test_random(150, 0, 0);
    test_backpressure();
    test_random(150, 81, 0);
    test_random(150, 0, 81);
    test_random(150, 22, 22);

    in_if.valid    <= 1'b0;
    sink_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
rtl/core/tlrp_pkg.sv
rtl/core/tlrp_ifs.sv
rtl/core/tlrp_in_reg.sv
rtl/core/tlrp_parse.sv
rtl/core/tlrp_out_reg.sv
rtl/core/typed_length_prefixed_record_parser_top.sv
sim/typed_length_prefixed_record_parser_top_tb.sv
